// ===== sv/spq_pkg.sv =====
// spq_pkg: shared constants and types for the sorted priority queue.
// Used by the interfaces, the storage cell and the top level; no dependencies.
package spq_pkg;

  localparam int DEPTH        = 16;
  localparam int DATA_WIDTH   = 32;
  localparam int MAX_PRIORITY = 15;

  // Port field widths are fixed.
  localparam int VALUE_W = 32;
  localparam int PRIO_IN_W = 4;

  // Stored priority width follows from the largest priority.
  localparam int PRIO_W = $clog2(MAX_PRIORITY + 1);

  localparam logic KIND_ADD    = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  // Broadcast operation seen by every cell in the same cycle.
  typedef struct packed {
    logic                  add;
    logic                  rem;
    logic [PRIO_W-1:0]     prio;
    logic [DATA_WIDTH-1:0] value;
  } op_t;

  // Contents of one cell as its neighbors see them.
  typedef struct packed {
    logic                  valid;
    logic                  keep;   // entry stays ahead of the incoming add
    logic [PRIO_W-1:0]     prio;
    logic [DATA_WIDTH-1:0] value;
  } slot_t;

endpackage

// ===== sv/spq_if.sv =====
// spq_if: valid/ready channel interfaces for queue requests and results.
// Depends on spq_pkg for the field widths.
interface spq_in_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [spq_pkg::VALUE_W-1:0]   item_value;
  logic [spq_pkg::PRIO_IN_W-1:0] item_priority;

  modport source (output valid, kind, item_value, item_priority, input ready);
  modport sink   (input valid, kind, item_value, item_priority, output ready);
endinterface

interface spq_out_if;
  logic                         valid;
  logic                         ready;
  logic                         ok;
  logic [spq_pkg::VALUE_W-1:0]   out_value;
  logic [spq_pkg::PRIO_IN_W-1:0] out_priority;

  modport source (output valid, ok, out_value, out_priority, input ready);
  modport sink   (input valid, ok, out_value, out_priority, output ready);
endinterface

// ===== sv/spq_cell.sv =====
// spq_cell: one slot of the sorted chain; holds an entry and shifts with its neighbors.
// Depends on spq_pkg for op_t and slot_t.
module spq_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  spq_pkg::op_t   op,
  input  spq_pkg::slot_t prv,
  input  spq_pkg::slot_t nxt,
  output spq_pkg::slot_t cur
);

  logic                           valid_r, valid_nxt;
  logic [spq_pkg::PRIO_W-1:0]     prio_r, prio_nxt;
  logic [spq_pkg::DATA_WIDTH-1:0] value_r, value_nxt;
  logic                           keep;

  // Equal priority stays ahead: arrival order among equals.
  assign keep = valid_r && (prio_r >= op.prio);

  always_comb begin
    cur.valid = valid_r;
    cur.keep  = keep;
    cur.prio  = prio_r;
    cur.value = value_r;
  end

  always_comb begin
    valid_nxt = valid_r;
    prio_nxt  = prio_r;
    value_nxt = value_r;
    if (op.rem) begin
      // advance toward the head
      valid_nxt = nxt.valid;
      prio_nxt  = nxt.prio;
      value_nxt = nxt.value;
    end else if (op.add && !keep) begin
      if (prv.keep) begin
        valid_nxt = 1'b1;
        prio_nxt  = op.prio;
        value_nxt = op.value;
      end else begin
        valid_nxt = prv.valid;
        prio_nxt  = prv.prio;
        value_nxt = prv.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prio_r  <= prio_nxt;
    value_r <= value_nxt;
  end

endmodule

// ===== sv/sorted_priority_queue.sv =====
// sorted_priority_queue: bounded priority queue as a shift chain of DEPTH cells.
// An accepted item's result is loaded into the output register in the cycle after acceptance.
// One add or remove per cycle unless a result is stalled; the whole chain updates at once.
// Reset (synchronous, rst_n low): all cells empty, output register empty.
// Depends on spq_pkg, spq_in_if/spq_out_if and spq_cell.
module sorted_priority_queue (
  input logic      clk,
  input logic      rst_n,
  spq_in_if.sink   in_ch,
  spq_out_if.source out_ch
);

  localparam int N = spq_pkg::DEPTH;

  spq_pkg::slot_t slots [N];
  spq_pkg::slot_t prv_s [N];
  spq_pkg::slot_t nxt_s [N];
  spq_pkg::op_t   op;

  logic full, empty, accept;
  logic [spq_pkg::PRIO_W-1:0] sat_prio;

  logic                          out_valid_r, out_valid_nxt;
  logic                          ok_r, ok_nxt;
  logic [spq_pkg::VALUE_W-1:0]   value_r, value_nxt;
  logic [spq_pkg::PRIO_IN_W-1:0] prio_r, prio_nxt;

  // Entries are packed from the head, so the ends tell fill state.
  assign full  = slots[N-1].valid;
  assign empty = !slots[0].valid;

  // Take a new item whenever the result register is free or being drained.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // Clamp priorities beyond the configured maximum.
  always_comb begin
    if (int'(in_ch.item_priority) > spq_pkg::MAX_PRIORITY) begin
      sat_prio = spq_pkg::PRIO_W'(spq_pkg::MAX_PRIORITY);
    end else begin
      sat_prio = spq_pkg::PRIO_W'(in_ch.item_priority);
    end
  end

  // Broadcast the operation; refused ones leave the chain untouched.
  always_comb begin
    op.add   = accept && (in_ch.kind == spq_pkg::KIND_ADD) && !full;
    op.rem   = accept && (in_ch.kind == spq_pkg::KIND_REMOVE) && !empty;
    op.prio  = sat_prio;
    op.value = spq_pkg::DATA_WIDTH'(in_ch.item_value);
  end

  // Neighbor wiring: the head sees a virtual entry that always stays ahead,
  // the tail sees an empty slot behind it.
  always_comb begin
    for (int i = 0; i < N; i++) begin
      if (i == 0) begin
        prv_s[i]       = '0;
        prv_s[i].keep  = 1'b1;
      end else begin
        prv_s[i] = slots[i-1];
      end
      if (i == N - 1) begin
        nxt_s[i] = '0;
      end else begin
        nxt_s[i] = slots[i+1];
      end
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_cell
    spq_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .op    (op),
      .prv   (prv_s[g]),
      .nxt   (nxt_s[g]),
      .cur   (slots[g])
    );
  end

  // Result register: ok plus the popped head on a successful remove.
  always_comb begin
    out_valid_nxt = out_valid_r;
    ok_nxt        = ok_r;
    value_nxt     = value_r;
    prio_nxt      = prio_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (accept) begin
      out_valid_nxt = 1'b1;
      ok_nxt        = op.add || op.rem;
      value_nxt     = '0;
      prio_nxt      = '0;
      if (op.rem) begin
        value_nxt = spq_pkg::VALUE_W'(slots[0].value);
        prio_nxt  = spq_pkg::PRIO_IN_W'(slots[0].prio);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ok_r    <= ok_nxt;
    value_r <= value_nxt;
    prio_r  <= prio_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.ok           = ok_r;
  assign out_ch.out_value    = value_r;
  assign out_ch.out_priority = prio_r;

endmodule

// ===== sv/spq_checker.sv =====
// spq_checker: port-level assertions for sorted_priority_queue, attached by bind.
// Depends on spq_pkg for field widths.
module spq_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_ok,
  input logic [spq_pkg::VALUE_W-1:0]   out_value,
  input logic [spq_pkg::PRIO_IN_W-1:0] out_priority
);

  // every accepted item yields a result on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted item produced no result");

  // never take an item while a result is stuck
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted over a stalled result");

  // refused operations carry zero payload
  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> (out_value == '0) && (out_priority == '0))
    else $error("refused result with nonzero payload");

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_ok)
      && $stable(out_value) && $stable(out_priority))
    else $error("stalled result changed");

  // no result comes out of reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_ok       (out_ch.ok),
  .out_value    (out_ch.out_value),
  .out_priority (out_ch.out_priority)
);

// ===== tb/spq_checker.sv =====
// spq_scoreboard: shadow queue and scoreboard for sorted_priority_queue.
// Watches the request and reply channels and counts mismatches.
// Depends on spq_pkg and the spq_in_if / spq_out_if interfaces.
`timescale 1ns / 1ps

module spq_scoreboard (
  input  logic clk,
  input  logic rst_n,
  spq_in_if    req_ch,
  spq_out_if   rsp_ch,
  output int   fail_count,
  output int   replies_owed
);

  typedef struct packed {
    logic                          ok;
    logic [spq_pkg::VALUE_W-1:0]   value;
    logic [spq_pkg::PRIO_IN_W-1:0] prio;
  } reply_t;

  // Shadow store, head at index 0, kept in service order.
  logic [spq_pkg::DATA_WIDTH-1:0] shadow_value [spq_pkg::DEPTH];
  logic [spq_pkg::PRIO_W-1:0]     shadow_prio  [spq_pkg::DEPTH];
  int                             shadow_count = 0;

  reply_t awaited_replies [$];
  int     mismatches = 0;

  assign fail_count = mismatches;

  task automatic report_mismatch(input string msg);
    $display("%0t spq_scoreboard: %s", $time, msg);
    mismatches++;
  endtask

  // Apply one request to the shadow store and return the reply it owes.
  function automatic reply_t serve_request(input logic                          kind,
                                           input logic [spq_pkg::VALUE_W-1:0]   value,
                                           input logic [spq_pkg::PRIO_IN_W-1:0] prio);
    reply_t                     r;
    logic [spq_pkg::PRIO_W-1:0] p;
    int                         pos;
    int                         k;
    r = '0;
    if (kind == spq_pkg::KIND_ADD) begin
      if (shadow_count < spq_pkg::DEPTH) begin
        p = (prio > spq_pkg::MAX_PRIORITY) ? spq_pkg::PRIO_W'(spq_pkg::MAX_PRIORITY)
                                           : spq_pkg::PRIO_W'(prio);
        // Land behind every entry of equal or higher priority.
        pos = 0;
        while (pos < shadow_count && shadow_prio[pos] >= p) pos++;
        for (k = shadow_count; k > pos; k--) begin
          shadow_value[k] = shadow_value[k-1];
          shadow_prio[k]  = shadow_prio[k-1];
        end
        shadow_value[pos] = spq_pkg::DATA_WIDTH'(value);
        shadow_prio[pos]  = p;
        shadow_count++;
        r.ok = 1'b1;
      end
    end else if (shadow_count != 0) begin
      r.ok    = 1'b1;
      r.value = spq_pkg::VALUE_W'(shadow_value[0]);
      r.prio  = spq_pkg::PRIO_IN_W'(shadow_prio[0]);
      for (k = 1; k < shadow_count; k++) begin
        shadow_value[k-1] = shadow_value[k];
        shadow_prio[k-1]  = shadow_prio[k];
      end
      shadow_count--;
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    reply_t want;
    if (!rst_n) begin
      shadow_count = 0;
      awaited_replies.delete();
    end else begin
      if (req_ch.valid && req_ch.ready)
        awaited_replies.push_back(serve_request(req_ch.kind, req_ch.item_value,
                                                req_ch.item_priority));
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (awaited_replies.size() == 0) begin
          report_mismatch($sformatf("reply with no request pending: ok=%b value=%h prio=%0d",
                                    rsp_ch.ok, rsp_ch.out_value, rsp_ch.out_priority));
        end else begin
          want = awaited_replies.pop_front();
          if (rsp_ch.ok !== want.ok)
            report_mismatch($sformatf("ok: got %b, want %b", rsp_ch.ok, want.ok));
          if (rsp_ch.out_value !== want.value)
            report_mismatch($sformatf("out_value: got %h, want %h",
                                      rsp_ch.out_value, want.value));
          if (rsp_ch.out_priority !== want.prio)
            report_mismatch($sformatf("out_priority: got %0d, want %0d",
                                      rsp_ch.out_priority, want.prio));
        end
      end
    end
    replies_owed <= awaited_replies.size();
  end

endmodule

// ===== tb/tb_sorted_priority_queue.sv =====
// tb_sorted_priority_queue: stimulus and verdict for sorted_priority_queue.
// Drives requests and reply backpressure; spq_scoreboard predicts and compares.
// Depends on spq_pkg, spq_in_if / spq_out_if, the block and spq_scoreboard.
`timescale 1ns / 1ps

module tb_sorted_priority_queue;

  localparam int RANDOM_ITEMS = 850;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RESET_CYCLES = 8;

  logic clk = 1'b0;
  logic rst_n;
  // Calm phases switch off idling on both sides to get back-to-back traffic.
  logic calm = 1'b0;
  int   cycle_count = 0;
  int   ready_hold = 0;
  int   fail_count;
  int   replies_owed;

  spq_in_if  req_ch ();
  spq_out_if rsp_ch ();

  sorted_priority_queue u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (rsp_ch)
  );

  spq_scoreboard u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_ch       (req_ch),
    .rsp_ch       (rsp_ch),
    .fail_count   (fail_count),
    .replies_owed (replies_owed)
  );

  always #10 clk = ~clk;

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  // Hold ready high or low for a random stretch, then pick again.
  always @(posedge clk) begin
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (calm || $urandom_range(0, 99) < 60) begin
      rsp_ch.ready <= 1'b1;
      ready_hold   <= $urandom_range(0, calm ? 30 : 6);
    end else begin
      rsp_ch.ready <= 1'b0;
      ready_hold   <= pick_gap();
    end
  end

  // Watchdog: end the run with an error once it runs past the cycle limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[sorted_priority_queue] ERROR");
      $finish;
    end
  end

  // Present one item after a random gap and hold it until accepted.
  // Called in the step of the previous acceptance, so valid gets one update.
  task automatic drive_request(input logic                          kind,
                               input logic [spq_pkg::VALUE_W-1:0]   value,
                               input logic [spq_pkg::PRIO_IN_W-1:0] prio);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.kind          <= kind;
    req_ch.item_value    <= value;
    req_ch.item_priority <= prio;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
  endtask

  initial begin : stimulus
    int                            sent;
    int                            phase_len;
    int                            add_weight;
    int                            i;
    logic                          narrow;
    logic                          kind;
    logic [spq_pkg::VALUE_W-1:0]   value;
    logic [spq_pkg::PRIO_IN_W-1:0] prio;

    rst_n                <= 1'b0;
    req_ch.valid         <= 1'b0;
    req_ch.kind          <= spq_pkg::KIND_ADD;
    req_ch.item_value    <= '0;
    req_ch.item_priority <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: remove from empty, extreme values and priorities, a tie at
    // the top priority, fill to the brim, refused add, then pop the head.
    drive_request(spq_pkg::KIND_REMOVE, $urandom, spq_pkg::PRIO_IN_W'($urandom));
    drive_request(spq_pkg::KIND_ADD, '0, '0);
    drive_request(spq_pkg::KIND_ADD, '1, spq_pkg::PRIO_IN_W'(spq_pkg::MAX_PRIORITY));
    drive_request(spq_pkg::KIND_ADD, spq_pkg::VALUE_W'(5),
                  spq_pkg::PRIO_IN_W'(spq_pkg::MAX_PRIORITY));
    for (i = 0; i < spq_pkg::DEPTH - 3; i++)
      drive_request(spq_pkg::KIND_ADD, $urandom, spq_pkg::PRIO_IN_W'((i % 5) * 3));
    drive_request(spq_pkg::KIND_ADD, spq_pkg::VALUE_W'(32'hA5A5_5A5A), '1);
    repeat (5) drive_request(spq_pkg::KIND_REMOVE, $urandom, spq_pkg::PRIO_IN_W'($urandom));

    // Random phases: lean toward filling, draining or balance so the queue
    // swings between full and empty; narrow priorities force many ties.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      phase_len = $urandom_range(15, 90);
      case ($urandom_range(0, 2))
        0:       add_weight = 25;
        1:       add_weight = 50;
        default: add_weight = 80;
      endcase
      calm   = ($urandom_range(0, 3) == 0);
      narrow = 1'($urandom_range(0, 1));
      repeat (phase_len) begin
        kind = ($urandom_range(0, 99) < add_weight) ? spq_pkg::KIND_ADD
                                                    : spq_pkg::KIND_REMOVE;
        case ($urandom_range(0, 9))
          0:       value = '0;
          1:       value = '1;
          default: value = $urandom;
        endcase
        prio = narrow ? spq_pkg::PRIO_IN_W'($urandom_range(0, 3))
                      : spq_pkg::PRIO_IN_W'($urandom_range(0, (1 << spq_pkg::PRIO_IN_W) - 1));
        drive_request(kind, value, prio);
        sent++;
      end
    end

    // Drop valid, let the checker see the last acceptance, then drain.
    req_ch.valid <= 1'b0;
    calm = 1'b0;
    @(posedge clk);
    while (replies_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0)
      $display("[sorted_priority_queue] OK");
    else
      $display("[sorted_priority_queue] ERROR");
    $finish;
  end

endmodule
